// ----- hdl/dxe_pkg.sv -----
// Shared types, constants and helper functions of the Dalvik integer execute unit.
package dxe_pkg;

   localparam int NUM_REGS_DEF = 256;
   localparam int QUEUE_DEPTH  = 2;
   localparam int DIV_STEPS    = 64;
   localparam int MUL_STEPS    = 3;

   localparam logic [31:0] CODE_UNITS_RST = 32'd1;
   localparam logic [19:0] MAX_STEPS_RST  = 20'd200000;

   localparam logic [1:0] KIND_BEGIN  = 2'd0;
   localparam logic [1:0] KIND_SETREG = 2'd1;
   localparam logic [1:0] KIND_EXEC   = 2'd2;

   localparam int          CSR_INDEX_W    = 1;
   localparam logic        CSR_CODE_UNITS = 1'b0;
   localparam logic        CSR_MAX_STEPS  = 1'b1;

   localparam logic [7:0] OP_BINOP      = 8'h90;
   localparam logic [7:0] OP_BINOP_WIDE = 8'h9b;
   localparam logic [7:0] OP_BINOP_FP   = 8'ha6;
   localparam logic [7:0] OP_2ADDR      = 8'hb0;
   localparam logic [7:0] OP_2ADDR_WIDE = 8'hbb;
   localparam logic [7:0] OP_2ADDR_FP   = 8'hc6;
   localparam logic [7:0] OP_LIT16      = 8'hd0;
   localparam logic [7:0] OP_RSUB16     = 8'hd1;
   localparam logic [7:0] OP_LIT8       = 8'hd8;
   localparam logic [7:0] OP_RSUB8      = 8'hd9;
   localparam logic [7:0] OP_IF_TEST    = 8'h32;
   localparam logic [7:0] OP_IF_TESTZ   = 8'h38;

   typedef enum logic [1:0] {ACT_NONE, ACT_BEGIN, ACT_SETREG, ACT_EXEC} act_type;

   typedef enum logic [2:0] {
      STAT_CONT, STAT_RET, STAT_END, STAT_UNSUP, STAT_LIMIT
   } status_type;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_AND, ALU_OR, ALU_XOR,
      ALU_SHL, ALU_SHR, ALU_USHR
   } alu_op_type;

   typedef enum logic [3:0] {
      UN_MOVE, UN_NEG_INT, UN_NOT_INT, UN_NEG, UN_NOT, UN_SX32, UN_SX8, UN_ZX16, UN_SX16
   } un_type;

   typedef enum logic [1:0] {VAL_IMM, VAL_UN, VAL_ALU} val_type;

   typedef enum logic [2:0] {COND_EQ, COND_NE, COND_LT, COND_GE, COND_GT, COND_LE} cond_type;

   typedef enum logic [2:0] {
      BK_CLEAR, BK_IDLE, BK_EXEC, BK_WAIT, BK_BEGIN_RSP
   } back_state_type;

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_type;

   typedef struct packed {
      act_type     act;
      logic        unsup;
      logic        ret;
      logic        ret_val;
      logic        wr_en;
      logic        dst_ok;
      logic        a_ok;
      logic        b_ok;
      logic [15:0] dst;
      logic [15:0] src_a;
      logic [15:0] src_b;
      val_type     vsel;
      un_type      un;
      alu_op_type  alu;
      logic        a_sx32;
      logic        b_imm;
      logic        swap;
      logic        is_if;
      cond_type    cnd;
      logic        cmp_zero;
      logic [31:0] adv;
      logic [31:0] adv_br;
      logic [63:0] imm;
   } dec_type;

   function automatic logic [63:0] sx8(input logic [7:0] x);
      return {{56{x[7]}}, x};
   endfunction

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

endpackage

// ----- hdl/dxe_front.sv -----
// Front end: accepts transactions and decodes them into execution records.
module dxe_front #(
   parameter int NUM_REGS = dxe_pkg::NUM_REGS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_reg_index,
   input  logic [63:0]      req_reg_value,
   input  logic [7:0]       req_opcode,
   input  logic [7:0]       req_operand_byte,
   input  logic [15:0]      req_unit_one,
   input  logic [15:0]      req_unit_two,
   input  logic [15:0]      req_unit_three,
   input  logic [15:0]      req_unit_four,
   input  logic             q_full,
   input  logic             back_busy,
   output logic             push,
   output dxe_pkg::dec_type push_data
);
   import dxe_pkg::*;

   logic    blocked_ff;
   logic    blocked_in;
   dec_type d;
   logic [7:0]  op;
   logic [7:0]  diff;
   logic [15:0] ra;
   logic [15:0] rb;
   logic [15:0] b1;

   assign blocked_in = back_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b1;
      end else begin
         blocked_ff <= blocked_in;
      end
   end

   assign req_stall = q_full || blocked_ff;
   assign push      = req_valid && !req_stall;

   always_comb begin
      d    = '0;
      op   = req_opcode;
      diff = 8'd0;
      ra   = {12'd0, req_operand_byte[3:0]};
      rb   = {12'd0, req_operand_byte[7:4]};
      b1   = {8'd0, req_operand_byte};
      d.act  = ACT_NONE;
      d.vsel = VAL_IMM;
      d.un   = UN_MOVE;
      d.alu  = ALU_ADD;
      d.cnd  = COND_EQ;
      case (req_kind)
         KIND_BEGIN: begin
            d.act = ACT_BEGIN;
         end
         KIND_SETREG: begin
            d.act   = ACT_SETREG;
            d.wr_en = 1'b1;
            d.dst   = {8'd0, req_reg_index};
            d.imm   = req_reg_value;
         end
         KIND_EXEC: begin
            d.act = ACT_EXEC;
            if (op == 8'h00 || op == 8'h1d || op == 8'h1e) begin
               d.adv = 32'd1;
            end else if (op == 8'h01 || op == 8'h04 || op == 8'h07) begin
               d.wr_en = 1'b1; d.dst = ra; d.src_a = rb; d.vsel = VAL_UN; d.adv = 32'd1;
            end else if (op == 8'h02 || op == 8'h05 || op == 8'h08) begin
               d.wr_en = 1'b1; d.dst = b1; d.src_a = req_unit_one; d.vsel = VAL_UN;
               d.adv = 32'd2;
            end else if (op == 8'h03 || op == 8'h06 || op == 8'h09) begin
               d.wr_en = 1'b1; d.dst = req_unit_one; d.src_a = req_unit_two;
               d.vsel = VAL_UN; d.adv = 32'd3;
            end else if (op >= 8'h0a && op <= 8'h0c) begin
               d.wr_en = 1'b1; d.dst = b1; d.adv = 32'd1;
            end else if (op == 8'h0e || op == 8'h27) begin
               d.ret = 1'b1;
            end else if (op >= 8'h0f && op <= 8'h11) begin
               d.ret = 1'b1; d.ret_val = 1'b1; d.src_a = b1;
            end else if (op == 8'h12) begin
               d.wr_en = 1'b1; d.dst = ra;
               d.imm = {{60{req_operand_byte[7]}}, req_operand_byte[7:4]};
               d.adv = 32'd1;
            end else if (op == 8'h13 || op == 8'h16) begin
               d.wr_en = 1'b1; d.dst = b1; d.imm = sx16(req_unit_one); d.adv = 32'd2;
            end else if (op == 8'h14 || op == 8'h17) begin
               d.wr_en = 1'b1; d.dst = b1; d.imm = sx32({req_unit_two, req_unit_one});
               d.adv = 32'd3;
            end else if (op == 8'h15) begin
               d.wr_en = 1'b1; d.dst = b1;
               d.imm = {{32{req_unit_one[15]}}, req_unit_one, 16'd0}; d.adv = 32'd2;
            end else if (op == 8'h18) begin
               d.wr_en = 1'b1; d.dst = b1;
               d.imm = {req_unit_four, req_unit_three, req_unit_two, req_unit_one};
               d.adv = 32'd5;
            end else if (op == 8'h19) begin
               d.wr_en = 1'b1; d.dst = b1; d.imm = {req_unit_one, 48'd0}; d.adv = 32'd2;
            end else if (op == 8'h1a || op == 8'h1c || op == 8'h22) begin
               d.wr_en = 1'b1; d.dst = b1; d.adv = 32'd2;
            end else if (op == 8'h1b) begin
               d.wr_en = 1'b1; d.dst = b1; d.adv = 32'd3;
            end else if (op == 8'h1f) begin
               d.adv = 32'd2;
            end else if (op == 8'h20) begin
               d.wr_en = 1'b1; d.dst = ra; d.imm = 64'd1; d.adv = 32'd2;
            end else if (op == 8'h21) begin
               d.wr_en = 1'b1; d.dst = ra; d.adv = 32'd1;
            end else if (op == 8'h23 || (op >= 8'h52 && op <= 8'h58)) begin
               d.wr_en = 1'b1; d.dst = ra; d.adv = 32'd2;
            end else if ((op >= 8'h24 && op <= 8'h26) || op == 8'h2b || op == 8'h2c) begin
               d.adv = 32'd3;
            end else if (op == 8'h28) begin
               if (req_operand_byte == 8'd0) begin
                  d.ret = 1'b1;
               end else begin
                  d.adv = 32'(sx8(req_operand_byte));
               end
            end else if (op == 8'h29) begin
               d.adv = (req_unit_one != 16'd0) ? 32'(sx16(req_unit_one)) : 32'd2;
            end else if (op == 8'h2a) begin
               d.adv = ({req_unit_two, req_unit_one} != 32'd0) ?
                       {req_unit_two, req_unit_one} : 32'd3;
            end else if ((op >= 8'h2d && op <= 8'h31) || (op >= 8'h44 && op <= 8'h4a) ||
                         (op >= 8'h60 && op <= 8'h66)) begin
               d.wr_en = 1'b1; d.dst = b1; d.adv = 32'd2;
            end else if (op >= OP_IF_TEST && op <= 8'h37) begin
               diff = op - OP_IF_TEST;
               d.is_if = 1'b1; d.cnd = cond_type'(diff[2:0]);
               d.src_a = ra; d.src_b = rb; d.adv = 32'd2;
               d.adv_br = (req_unit_one != 16'd0) ? 32'(sx16(req_unit_one)) : 32'd2;
            end else if (op >= OP_IF_TESTZ && op <= 8'h3d) begin
               diff = op - OP_IF_TESTZ;
               d.is_if = 1'b1; d.cnd = cond_type'(diff[2:0]); d.cmp_zero = 1'b1;
               d.src_a = b1; d.adv = 32'd2;
               d.adv_br = (req_unit_one != 16'd0) ? 32'(sx16(req_unit_one)) : 32'd2;
            end else if ((op >= 8'h4b && op <= 8'h51) || (op >= 8'h59 && op <= 8'h5f) ||
                         (op >= 8'h67 && op <= 8'h6d)) begin
               d.adv = 32'd2;
            end else if ((op >= 8'h6e && op <= 8'h72) || (op >= 8'h74 && op <= 8'h78)) begin
               d.adv = 32'd3;
            end else if (op >= 8'h7b && op <= 8'h8f) begin
               d.wr_en = 1'b1; d.dst = ra; d.src_a = rb; d.vsel = VAL_UN; d.adv = 32'd1;
               case (op)
                  8'h7b: d.un = UN_NEG_INT;
                  8'h7c: d.un = UN_NOT_INT;
                  8'h7d: d.un = UN_NEG;
                  8'h7e: d.un = UN_NOT;
                  8'h81: d.un = UN_SX32;
                  8'h84: d.un = UN_SX32;
                  8'h8d: d.un = UN_SX8;
                  8'h8e: d.un = UN_ZX16;
                  8'h8f: d.un = UN_SX16;
                  default: d.un = UN_MOVE;
               endcase
            end else if (op >= OP_BINOP && op <= 8'haf) begin
               diff = (op < OP_BINOP_WIDE) ? op - OP_BINOP :
                      (op < OP_BINOP_FP) ? op - OP_BINOP_WIDE : op - OP_BINOP_FP;
               d.wr_en = 1'b1; d.dst = b1; d.vsel = VAL_ALU; d.alu = alu_op_type'(diff[3:0]);
               d.src_a = {8'd0, req_unit_one[7:0]}; d.src_b = {8'd0, req_unit_one[15:8]};
               d.adv = 32'd2;
            end else if (op >= OP_2ADDR && op <= 8'hcf) begin
               diff = (op < OP_2ADDR_WIDE) ? op - OP_2ADDR :
                      (op < OP_2ADDR_FP) ? op - OP_2ADDR_WIDE : op - OP_2ADDR_FP;
               d.wr_en = 1'b1; d.dst = ra; d.vsel = VAL_ALU; d.alu = alu_op_type'(diff[3:0]);
               d.src_a = ra; d.src_b = rb; d.adv = 32'd1;
            end else if (op >= OP_LIT16 && op <= 8'hd7) begin
               diff = op - OP_LIT16;
               d.wr_en = 1'b1; d.dst = ra; d.vsel = VAL_ALU; d.alu = alu_op_type'(diff[3:0]);
               d.src_a = rb; d.a_sx32 = 1'b1; d.b_imm = 1'b1; d.imm = sx16(req_unit_one);
               d.swap = (op == OP_RSUB16); d.adv = 32'd2;
            end else if (op >= OP_LIT8 && op <= 8'he2) begin
               diff = op - OP_LIT8;
               d.wr_en = 1'b1; d.dst = b1; d.vsel = VAL_ALU; d.alu = alu_op_type'(diff[3:0]);
               d.src_a = {8'd0, req_unit_one[7:0]}; d.a_sx32 = 1'b1; d.b_imm = 1'b1;
               d.imm = sx8(req_unit_one[15:8]); d.swap = (op == OP_RSUB8); d.adv = 32'd2;
            end else begin
               d.unsup = 1'b1;
            end
         end
         default: d.act = ACT_NONE;
      endcase
      d.dst_ok = ({1'b0, d.dst} < 17'(NUM_REGS));
      d.a_ok   = ({1'b0, d.src_a} < 17'(NUM_REGS));
      d.b_ok   = ({1'b0, d.src_b} < 17'(NUM_REGS));
   end

   assign push_data = d;

endmodule

// ----- hdl/dxe_queue.sv -----
// Short queue of decoded transactions between the front end and the back end.
module dxe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dxe_pkg::dec_type push_data,
   input  logic             pop,
   output dxe_pkg::dec_type head,
   output logic             empty,
   output logic             full
);
   import dxe_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dec_type         entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/dxe_md.sv -----
// Multi-cycle multiply, divide and remainder unit on 64-bit operands.
module dxe_md (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dxe_pkg::alu_op_type op,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   output logic                done,
   output logic [63:0]         result
);
   import dxe_pkg::*;

   localparam int SW = $clog2(DIV_STEPS);

   md_state_type state_ff;
   md_state_type state_in;
   logic [SW-1:0] cnt_ff;
   logic [63:0]   a_ff;
   logic [63:0]   b_ff;
   logic [63:0]   lo_ff;
   logic [31:0]   cross_ff;
   logic [63:0]   num_ff;
   logic [63:0]   rem_ff;
   logic          neg_a_ff;
   logic          neg_b_ff;
   logic          zero_ff;
   logic          is_rem_ff;
   logic [31:0]   mx;
   logic [31:0]   my;
   logic [63:0]   prod;
   logic [64:0]   rem_sh;
   logic          fits;
   logic [63:0]   quo_res;
   logic [63:0]   rem_res;

   always_comb begin
      mx = a_ff[31:0];
      my = b_ff[31:0];
      if (cnt_ff == SW'(1)) begin
         my = b_ff[63:32];
      end else if (cnt_ff == SW'(2)) begin
         mx = a_ff[63:32];
      end
   end

   assign prod   = mx * my;
   assign rem_sh = {rem_ff, num_ff[63]};
   assign fits   = (rem_sh >= {1'b0, b_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               state_in = (op == ALU_MUL) ? MD_MUL : MD_DIV;
            end
         end
         MD_MUL: begin
            if (cnt_ff == SW'(MUL_STEPS - 1)) begin
               state_in = MD_DONE;
            end
         end
         MD_DIV: begin
            if (cnt_ff == SW'(DIV_STEPS - 1)) begin
               state_in = MD_DONE;
            end
         end
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         MD_IDLE: begin
            cnt_ff    <= '0;
            a_ff      <= a;
            b_ff      <= b;
            neg_a_ff  <= a[63];
            neg_b_ff  <= b[63];
            zero_ff   <= (b == 64'd0);
            is_rem_ff <= (op == ALU_REM);
            num_ff    <= a[63] ? 64'd0 - a : a;
            rem_ff    <= 64'd0;
            if (start && op != ALU_MUL) begin
               b_ff <= b[63] ? 64'd0 - b : b;
            end
         end
         MD_MUL: begin
            cnt_ff <= cnt_ff + SW'(1);
            if (cnt_ff == SW'(0)) begin
               lo_ff <= prod;
            end else if (cnt_ff == SW'(1)) begin
               cross_ff <= prod[31:0];
            end else begin
               cross_ff <= cross_ff + prod[31:0];
            end
         end
         MD_DIV: begin
            cnt_ff <= cnt_ff + SW'(1);
            if (fits) begin
               rem_ff <= 64'(rem_sh - {1'b0, b_ff});
               num_ff <= {num_ff[62:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[63:0];
               num_ff <= {num_ff[62:0], 1'b0};
            end
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   assign quo_res = (neg_a_ff != neg_b_ff) ? 64'd0 - num_ff : num_ff;
   assign rem_res = neg_a_ff ? 64'd0 - rem_ff : rem_ff;
   assign done    = (state_ff == MD_DONE);

   always_comb begin
      if (zero_ff && state_ff == MD_DONE && cnt_ff == SW'(DIV_STEPS - 1) && !done) begin
         result = 64'd0;
      end else if (cnt_ff == SW'(MUL_STEPS) && state_ff == MD_DONE && !zero_ff) begin
         result = lo_ff + {cross_ff, 32'd0};
      end else if (zero_ff && cnt_ff != SW'(MUL_STEPS)) begin
         result = 64'd0;
      end else if (cnt_ff == SW'(MUL_STEPS)) begin
         result = lo_ff + {cross_ff, 32'd0};
      end else begin
         result = is_rem_ff ? rem_res : quo_res;
      end
   end

endmodule

// ----- hdl/dxe_back.sv -----
// Back end: register file, program counter, step budget and instruction execution.
module dxe_back #(
   parameter int NUM_REGS = dxe_pkg::NUM_REGS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [dxe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                 csr_wdata,
   input  dxe_pkg::dec_type            q_head,
   input  logic                        q_empty,
   output logic                        pop,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [31:0]                 rsp_next_pc,
   output logic [63:0]                 rsp_return_value
);
   import dxe_pkg::*;

   localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   back_state_type state_ff;
   back_state_type state_in;
   dec_type        cur_ff;
   logic [63:0]    regs_mem [NUM_REGS];
   logic [63:0]    rdata_a_ff;
   logic [63:0]    rdata_b_ff;
   logic [IW-1:0]  clr_ff;
   logic           begin_ff;
   logic [31:0]    pc_ff;
   logic [19:0]    step_ff;
   logic [31:0]    code_units_ff;
   logic [19:0]    max_steps_ff;
   logic           md_have_ff;
   logic [63:0]    md_res_ff;
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [31:0]    rsp_pc_ff;
   logic [63:0]    rsp_retv_ff;

   logic           md_start;
   logic           md_done;
   logic [63:0]    md_result;
   logic           emit;
   logic           fin_write;
   logic           out_free;
   logic [63:0]    va;
   logic [63:0]    vb;
   logic [63:0]    x;
   logic [63:0]    y;
   logic [63:0]    opa;
   logic [63:0]    opb;
   logic [5:0]     sh;
   logic [63:0]    alu_v;
   logic [63:0]    un_v;
   logic [63:0]    value;
   logic [63:0]    cb;
   logic           slt_ab;
   logic           slt_ba;
   logic           taken;
   logic           is_exec;
   logic           fault;
   logic           is_md;
   logic           need_md;
   logic           do_write;
   status_type     st;
   logic [31:0]    npc;
   logic           mem_we;
   logic [IW-1:0]  mem_waddr;
   logic [63:0]    mem_wdata;

   dxe_md u_md (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .op     (cur_ff.alu),
      .a      (opa),
      .b      (opb),
      .done   (md_done),
      .result (md_result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign busy     = (state_ff == BK_CLEAR);

   always_comb begin
      va     = cur_ff.a_ok ? rdata_a_ff : 64'd0;
      vb     = cur_ff.b_ok ? rdata_b_ff : 64'd0;
      x      = cur_ff.a_sx32 ? sx32(va[31:0]) : va;
      y      = cur_ff.b_imm ? cur_ff.imm : vb;
      opa    = cur_ff.swap ? y : x;
      opb    = cur_ff.swap ? x : y;
      sh     = opb[5:0];
      case (cur_ff.alu)
         ALU_ADD:  alu_v = opa + opb;
         ALU_SUB:  alu_v = opa - opb;
         ALU_MUL:  alu_v = md_res_ff;
         ALU_DIV:  alu_v = md_res_ff;
         ALU_REM:  alu_v = md_res_ff;
         ALU_AND:  alu_v = opa & opb;
         ALU_OR:   alu_v = opa | opb;
         ALU_XOR:  alu_v = opa ^ opb;
         ALU_SHL:  alu_v = opa << sh;
         ALU_SHR:  alu_v = $unsigned($signed(opa) >>> sh);
         ALU_USHR: alu_v = opa >> sh;
         default:  alu_v = 64'd0;
      endcase
      case (cur_ff.un)
         UN_NEG_INT: un_v = 64'd0 - sx32(va[31:0]);
         UN_NOT_INT: un_v = ~sx32(va[31:0]);
         UN_NEG:     un_v = 64'd0 - va;
         UN_NOT:     un_v = ~va;
         UN_SX32:    un_v = sx32(va[31:0]);
         UN_SX8:     un_v = sx8(va[7:0]);
         UN_ZX16:    un_v = {48'd0, va[15:0]};
         UN_SX16:    un_v = sx16(va[15:0]);
         default:    un_v = va;
      endcase
      case (cur_ff.vsel)
         VAL_UN:  value = un_v;
         VAL_ALU: value = alu_v;
         default: value = cur_ff.imm;
      endcase
      cb     = cur_ff.cmp_zero ? 64'd0 : vb;
      slt_ab = ($signed(va) < $signed(cb));
      slt_ba = ($signed(cb) < $signed(va));
      case (cur_ff.cnd)
         COND_EQ: taken = (va == cb);
         COND_NE: taken = (va != cb);
         COND_LT: taken = slt_ab;
         COND_GE: taken = !slt_ab;
         COND_GT: taken = slt_ba;
         default: taken = !slt_ba;
      endcase
      is_exec = (cur_ff.act == ACT_EXEC);
      st      = STAT_CONT;
      if (is_exec) begin
         if (step_ff >= max_steps_ff) begin
            st = STAT_LIMIT;
         end else if (pc_ff >= code_units_ff) begin
            st = STAT_END;
         end else if (cur_ff.unsup) begin
            st = STAT_UNSUP;
         end else if (cur_ff.ret) begin
            st = STAT_RET;
         end
      end
      fault   = (st == STAT_LIMIT) || (st == STAT_END) || (st == STAT_UNSUP);
      is_md   = (cur_ff.vsel == VAL_ALU) &&
                (cur_ff.alu == ALU_MUL || cur_ff.alu == ALU_DIV || cur_ff.alu == ALU_REM);
      need_md = is_exec && !fault && is_md && !md_have_ff;
      do_write = cur_ff.wr_en && cur_ff.dst_ok && !fault &&
                 (is_exec || cur_ff.act == ACT_SETREG);
      npc = (is_exec && st == STAT_CONT) ?
            pc_ff + ((cur_ff.is_if && taken) ? cur_ff.adv_br : cur_ff.adv) : pc_ff;
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      md_start  = 1'b0;
      emit      = 1'b0;
      fin_write = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == IW'(NUM_REGS - 1)) begin
               state_in = begin_ff ? BK_BEGIN_RSP : BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               state_in = (q_head.act == ACT_BEGIN) ? BK_CLEAR : BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (need_md) begin
               md_start = 1'b1;
               state_in = BK_WAIT;
            end else if (out_free) begin
               emit      = 1'b1;
               fin_write = do_write;
               state_in  = BK_IDLE;
            end
         end
         BK_WAIT: begin
            if (md_done) begin
               state_in = BK_EXEC;
            end
         end
         BK_BEGIN_RSP: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign mem_we    = (state_ff == BK_CLEAR) || fin_write;
   assign mem_waddr = (state_ff == BK_CLEAR) ? clr_ff : cur_ff.dst[IW-1:0];
   assign mem_wdata = (state_ff == BK_CLEAR) ? 64'd0 : value;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         regs_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rdata_a_ff <= regs_mem[q_head.src_a[IW-1:0]];
         rdata_b_ff <= regs_mem[q_head.src_b[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clr_ff        <= '0;
         begin_ff      <= 1'b0;
         pc_ff         <= 32'd0;
         step_ff       <= 20'd0;
         code_units_ff <= CODE_UNITS_RST;
         max_steps_ff  <= MAX_STEPS_RST;
         md_have_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CODE_UNITS: code_units_ff <= csr_wdata;
               CSR_MAX_STEPS:  max_steps_ff  <= csr_wdata[19:0];
               default:        max_steps_ff  <= max_steps_ff;
            endcase
         end
         if (state_ff == BK_CLEAR) begin
            clr_ff <= clr_ff + IW'(1);
         end
         if (pop) begin
            md_have_ff <= 1'b0;
            if (q_head.act == ACT_BEGIN) begin
               begin_ff <= 1'b1;
               clr_ff   <= '0;
               pc_ff    <= 32'd0;
               step_ff  <= 20'd0;
            end else begin
               begin_ff <= 1'b0;
            end
         end
         if (state_ff == BK_WAIT && md_done) begin
            md_have_ff <= 1'b1;
         end
         if (emit && state_ff == BK_EXEC && is_exec && !fault) begin
            step_ff <= step_ff + 20'd1;
            pc_ff   <= npc;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_head;
      end
      if (state_ff == BK_WAIT && md_done) begin
         md_res_ff <= md_result;
      end
      if (emit) begin
         if (state_ff == BK_BEGIN_RSP) begin
            rsp_status_ff <= STAT_CONT;
            rsp_pc_ff     <= 32'd0;
            rsp_retv_ff   <= 64'd0;
         end else begin
            rsp_status_ff <= st;
            rsp_pc_ff     <= npc;
            rsp_retv_ff   <= (st == STAT_RET && cur_ff.ret_val) ? va : 64'd0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_next_pc      = rsp_pc_ff;
   assign rsp_return_value = rsp_retv_ff;

endmodule

// ----- hdl/dalvik_integer_execute_unit_top.sv -----
// Top level of the Dalvik integer execute unit: front end, queue and back end.
// An accepted instruction waits in the queue, whose pop also reads the register file
// memory; the back end then executes it and writes back, one instruction at a time.
// Multiply, divide and remainder run in the shared iterative unit.
// Begin method sweeps the register file, one entry a cycle.
// Reset clears control state and then runs the same sweep, during which no transaction
// is accepted; configuration writes are taken throughout.
module dalvik_integer_execute_unit_top #(
   parameter int NUM_REGS = dxe_pkg::NUM_REGS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dxe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [7:0]                      req_reg_index,
   input  logic [63:0]                     req_reg_value,
   input  logic [7:0]                      req_opcode,
   input  logic [7:0]                      req_operand_byte,
   input  logic [15:0]                     req_unit_one,
   input  logic [15:0]                     req_unit_two,
   input  logic [15:0]                     req_unit_three,
   input  logic [15:0]                     req_unit_four,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic [31:0]                     rsp_next_pc,
   output logic [63:0]                     rsp_return_value
);
   import dxe_pkg::*;

   dec_type push_data;
   dec_type q_head;
   logic    push;
   logic    pop;
   logic    q_empty;
   logic    q_full;
   logic    back_busy;

   dxe_front #(.NUM_REGS(NUM_REGS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_reg_index    (req_reg_index),
      .req_reg_value    (req_reg_value),
      .req_opcode       (req_opcode),
      .req_operand_byte (req_operand_byte),
      .req_unit_one     (req_unit_one),
      .req_unit_two     (req_unit_two),
      .req_unit_three   (req_unit_three),
      .req_unit_four    (req_unit_four),
      .q_full           (q_full),
      .back_busy        (back_busy),
      .push             (push),
      .push_data        (push_data)
   );

   dxe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   dxe_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_head           (q_head),
      .q_empty          (q_empty),
      .pop              (pop),
      .busy             (back_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_return_value (rsp_return_value)
   );

endmodule
